// File: design/assert_macros.svh
// Assertion macros shared by the reducer RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with reset disable and a fixed report
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Clocked check with reset disable and a caller message
`define ASSERT_CLK_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

`endif

// File: design/mrnr_pkg.sv
// Types and constants of the masked residual norm reducer
package mrnr_pkg;

  localparam int DATA_W      = 32;
  localparam int POS_W       = 16;
  localparam int SUM_W       = 64;
  localparam int DOF_CNT_W   = 17;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int STEP_W      = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(31);
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // Register index codes (word index taken from paddr[2])
  localparam logic REG_TOTAL_DOF = 1'b0;

  // One classified item travelling from front to back
  typedef struct packed {
    logic [DATA_W-1:0] res_mag;
    logic [DATA_W-1:0] inc_mag;
    logic [POS_W-1:0]  pos;
    logic              counted;
    logic              last;
  } mrnr_item_t;

  // Vector summary handed from back to the finishing unit
  typedef struct packed {
    logic [DATA_W-1:0] res_max;
    logic [POS_W-1:0]  res_pos;
    logic [DATA_W-1:0] inc_max;
    logic [POS_W-1:0]  inc_pos;
    logic [SUM_W-1:0]  sum;
    logic              sat;
  } mrnr_summary_t;

  typedef enum logic [1:0] {
    FIN_IDLE,
    FIN_SQRT,
    FIN_DIV,
    FIN_OUT
  } fin_state_e;

endpackage

// File: design/mrnr_front.sv
// Front end: accepts items, forms magnitudes, mask and dof position
module mrnr_front #(
  parameter int MAX_DOFS    = 65536,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [31:0]        residual_value_i,
  input  logic signed [31:0]        increment_value_i,
  input  logic                      include_flag_i,
  input  logic                      boundary_flag_i,
  input  logic                      last_item_i,
  input  logic                      full_i,
  output logic                      push_o,
  output mrnr_pkg::mrnr_item_t      item_o
);
  import mrnr_pkg::*;

  localparam int PW = $clog2(MAX_DOFS);

  logic [PW-1:0]          pos_q, pos_d;
  logic [PW+POS_W-1:0]    pos_ext;
  logic [VALUE_WIDTH-1:0] res_raw, inc_raw, res_mag, inc_mag;

  // Stall while the queue has no room
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // Take the magnitude of the low value bits as two's complement
  assign res_raw = residual_value_i[VALUE_WIDTH-1:0];
  assign inc_raw = increment_value_i[VALUE_WIDTH-1:0];
  assign res_mag = res_raw[VALUE_WIDTH-1] ? (~res_raw + 1'b1) : res_raw;
  assign inc_mag = inc_raw[VALUE_WIDTH-1] ? (~inc_raw + 1'b1) : inc_raw;

  // Report the position in its low bits
  assign pos_ext = {{POS_W{1'b0}}, pos_q};

  always_comb begin
    item_o.res_mag = DATA_W'(res_mag);
    item_o.inc_mag = DATA_W'(inc_mag);
    item_o.pos     = pos_ext[POS_W-1:0];
    item_o.counted = include_flag_i && !boundary_flag_i;
    item_o.last    = last_item_i;
  end

  // Advance the position on every item, wrap at the dof limit, clear after last
  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (last_item_i || pos_q == PW'(MAX_DOFS - 1)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: design/mrnr_queue.sv
// Short item queue between front and back
`include "assert_macros.svh"

module mrnr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mrnr_pkg::mrnr_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output mrnr_pkg::mrnr_item_t head_o
);
  import mrnr_pkg::*;

  mrnr_item_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  `ASSERT_CLK(a_no_push_full, clk_i, rst_ni, push_i |-> !full_o)
  `ASSERT_CLK(a_count_up, clk_i, rst_ni,
    (push_i && !do_pop) |=> (count_q == $past(count_q) + 1'b1))

endmodule

// File: design/mrnr_back.sv
// Back end: squares residuals, tracks maxima and accumulates the sum
`include "assert_macros.svh"

module mrnr_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  mrnr_pkg::mrnr_item_t    q_head_i,
  output logic                    q_pop_o,
  input  logic                    fin_busy_i,
  output logic                    fin_start_o,
  output mrnr_pkg::mrnr_summary_t summary_o
);
  import mrnr_pkg::*;

  logic              advance, fire;
  logic              a_valid_q, a_valid_d;
  mrnr_item_t        a_item_q;
  logic [SUM_W-1:0]  a_sq_q;

  logic [DATA_W-1:0] res_max_q, res_max_d, inc_max_q, inc_max_d;
  logic [POS_W-1:0]  res_pos_q, res_pos_d, inc_pos_q, inc_pos_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              sat_q, sat_d;
  logic [SUM_W:0]    sum_wide;
  mrnr_summary_t     upd;

  // Hold everything while the finishing unit is busy
  assign advance = !fin_busy_i;
  assign fire    = advance && a_valid_q;
  assign q_pop_o = advance;
  assign a_valid_d = advance ? q_valid_i : a_valid_q;

  // Stage A: square the residual magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && q_valid_i) begin
      a_item_q <= q_head_i;
      a_sq_q   <= SUM_W'(q_head_i.res_mag) * SUM_W'(q_head_i.res_mag);
    end
  end

  // Update maxima (strict compare keeps the first position) and the sum
  assign sum_wide = {1'b0, sum_q} + {1'b0, a_sq_q};

  always_comb begin
    upd.res_max = res_max_q;
    upd.res_pos = res_pos_q;
    upd.inc_max = inc_max_q;
    upd.inc_pos = inc_pos_q;
    upd.sum     = sum_q;
    upd.sat     = sat_q;
    if (a_item_q.counted) begin
      if (a_item_q.res_mag > res_max_q) begin
        upd.res_max = a_item_q.res_mag;
        upd.res_pos = a_item_q.pos;
      end
      if (a_item_q.inc_mag > inc_max_q) begin
        upd.inc_max = a_item_q.inc_mag;
        upd.inc_pos = a_item_q.pos;
      end
      if (sum_wide[SUM_W]) begin
        upd.sum = '1;
        upd.sat = 1'b1;
      end else begin
        upd.sum = sum_wide[SUM_W-1:0];
      end
    end
  end

  assign summary_o   = upd;
  assign fin_start_o = fire && a_item_q.last;

  // Clear the vector state after a last item
  always_comb begin
    res_max_d = res_max_q;
    res_pos_d = res_pos_q;
    inc_max_d = inc_max_q;
    inc_pos_d = inc_pos_q;
    sum_d     = sum_q;
    sat_d     = sat_q;
    if (fire) begin
      if (a_item_q.last) begin
        res_max_d = '0;
        res_pos_d = '0;
        inc_max_d = '0;
        inc_pos_d = '0;
        sum_d     = '0;
        sat_d     = 1'b0;
      end else begin
        res_max_d = upd.res_max;
        res_pos_d = upd.res_pos;
        inc_max_d = upd.inc_max;
        inc_pos_d = upd.inc_pos;
        sum_d     = upd.sum;
        sat_d     = upd.sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_max_q <= '0;
      res_pos_q <= '0;
      inc_max_q <= '0;
      inc_pos_q <= '0;
      sum_q     <= '0;
      sat_q     <= 1'b0;
    end else begin
      res_max_q <= res_max_d;
      res_pos_q <= res_pos_d;
      inc_max_q <= inc_max_d;
      inc_pos_q <= inc_pos_d;
      sum_q     <= sum_d;
      sat_q     <= sat_d;
    end
  end

  `ASSERT_CLK(a_clear_after_last, clk_i, rst_ni,
    fin_start_o |=> (sum_q == '0 && !sat_q && res_max_q == '0 && inc_max_q == '0))

endmodule

// File: design/mrnr_finish.sv
// Finishing unit: iterative square root, iterative divide, result register
`include "assert_macros.svh"

module mrnr_finish (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  mrnr_pkg::mrnr_summary_t       summary_i,
  input  logic [mrnr_pkg::DOF_CNT_W-1:0] dof_count_i,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   residual_max_abs_o,
  output logic [15:0]                   residual_max_position_o,
  output logic [31:0]                   increment_max_abs_o,
  output logic [15:0]                   increment_max_position_o,
  output logic [31:0]                   l2_norm_value_o,
  output logic                          sum_saturated_o
);
  import mrnr_pkg::*;

  fin_state_e           state_q, state_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [SUM_W-1:0]     x_q, x_d, root_q, root_d, bit_q, bit_d, trial;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DOF_CNT_W-1:0] rem_q, rem_d, div_eff;
  logic [DOF_CNT_W:0]   rem_sh, rem_diff;
  logic                 rem_ge;
  mrnr_summary_t        res_q;

  assign busy_o      = (state_q != FIN_IDLE);
  assign out_valid_o = (state_q == FIN_OUT);

  // A zero divisor counts as one
  assign div_eff  = (dof_count_i == '0) ? DOF_CNT_W'(1) : dof_count_i;

  // One root digit per cycle
  assign trial    = root_q + bit_q;

  // One quotient bit per cycle
  assign rem_sh   = {rem_q, quo_q[DATA_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_eff};
  assign rem_ge   = (rem_sh >= {1'b0, div_eff});

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    x_d     = x_q;
    root_d  = root_q;
    bit_d   = bit_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    case (state_q)
      FIN_IDLE: begin
        if (start_i) begin
          state_d = FIN_SQRT;
          step_d  = LAST_STEP;
          x_d     = summary_i.sum;
          root_d  = '0;
          bit_d   = SUM_W'(1) << (SUM_W - 2);
        end
      end
      FIN_SQRT: begin
        if (x_q >= trial) begin
          x_d    = x_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = FIN_DIV;
          step_d  = LAST_STEP;
          quo_d   = root_d[DATA_W-1:0];
          rem_d   = '0;
        end
      end
      FIN_DIV: begin
        rem_d  = rem_ge ? rem_diff[DOF_CNT_W-1:0] : rem_sh[DOF_CNT_W-1:0];
        quo_d  = {quo_q[DATA_W-2:0], rem_ge};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = FIN_OUT;
        end
      end
      FIN_OUT: begin
        if (!out_stall_i) begin
          state_d = FIN_IDLE;
        end
      end
      default: begin
        state_d = FIN_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIN_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    if (start_i && state_q == FIN_IDLE) begin
      res_q <= summary_i;
    end
  end

  assign residual_max_abs_o       = res_q.res_max;
  assign residual_max_position_o  = res_q.res_pos;
  assign increment_max_abs_o      = res_q.inc_max;
  assign increment_max_position_o = res_q.inc_pos;
  assign sum_saturated_o          = res_q.sat;
  assign l2_norm_value_o          = quo_q;

  `ASSERT_CLK_MSG(a_start_when_idle, clk_i, rst_ni,
    start_i |-> (state_q == FIN_IDLE), "summary handed over while finishing unit busy")
  `ASSERT_CLK(a_root_to_div, clk_i, rst_ni,
    (state_q == FIN_SQRT && step_q == '0) |=> (state_q == FIN_DIV))

endmodule

// File: design/masked_residual_norm_reducer_top.sv
// Top level of the masked residual norm reducer
// Takes one dof item per cycle while its four-entry queue has room and retires
// one item per cycle in the back end (square, then compare and accumulate)
// while the finishing unit is idle. On an item marked last, the finishing unit
// runs an iterative square root, then an iterative division by total_dof_count,
// and holds the result until taken; the back end halts meanwhile.
// total_dof_count sits at byte address 0 and resets to 1.
module masked_residual_norm_reducer_top #(
  parameter int MAX_DOFS    = 65536,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mrnr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mrnr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mrnr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  // Item input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [31:0]                  residual_value_i,
  input  logic signed [31:0]                  increment_value_i,
  input  logic                                include_flag_i,
  input  logic                                boundary_flag_i,
  input  logic                                last_item_i,
  // Result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [31:0]                         residual_max_abs_o,
  output logic [15:0]                         residual_max_position_o,
  output logic [31:0]                         increment_max_abs_o,
  output logic [15:0]                         increment_max_position_o,
  output logic [31:0]                         l2_norm_value_o,
  output logic                                sum_saturated_o
);
  import mrnr_pkg::*;

  logic [DOF_CNT_W-1:0] dof_count_q;
  logic                 push, full, pop, q_valid, fin_busy, fin_start;
  mrnr_item_t           push_item, q_head;
  mrnr_summary_t        summary;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dof_count_q <= DOF_CNT_W'(1);
    end else if (psel && penable && pwrite && paddr[2] == REG_TOTAL_DOF) begin
      dof_count_q <= pwdata[DOF_CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TOTAL_DOF) begin
      prdata = APB_DATA_W'(dof_count_q);
    end
  end

  mrnr_front #(
    .MAX_DOFS    (MAX_DOFS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .residual_value_i  (residual_value_i),
    .increment_value_i (increment_value_i),
    .include_flag_i    (include_flag_i),
    .boundary_flag_i   (boundary_flag_i),
    .last_item_i       (last_item_i),
    .full_i            (full),
    .push_o            (push),
    .item_o            (push_item)
  );

  mrnr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  mrnr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (pop),
    .fin_busy_i  (fin_busy),
    .fin_start_o (fin_start),
    .summary_o   (summary)
  );

  mrnr_finish u_finish (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .start_i                  (fin_start),
    .summary_i                (summary),
    .dof_count_i              (dof_count_q),
    .busy_o                   (fin_busy),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall_i),
    .residual_max_abs_o       (residual_max_abs_o),
    .residual_max_position_o  (residual_max_position_o),
    .increment_max_abs_o      (increment_max_abs_o),
    .increment_max_position_o (increment_max_position_o),
    .l2_norm_value_o          (l2_norm_value_o),
    .sum_saturated_o          (sum_saturated_o)
  );

endmodule
